// ===== src/fds_pkg.sv =====
// Shared types, constants and codes for the frame duration sequencer.
package fds_pkg;

	// Sizing of the frame table and the time accumulator.
	localparam int MAX_FRAMES = 16;
	localparam int ACC_WIDTH  = 32;
	localparam int DUR_W      = 16;
	localparam int ELAP_W     = 16;
	localparam int POS_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int CFG_CNT_W  = 5;
	localparam int CMP_W      = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 1'd1;

	// Operation codes of an input word.
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_START  = 2'd2,
		OP_REWIND = 2'd3
	} fds_op_t;

	// Input word.
	typedef struct packed {
		fds_op_t           operation;
		logic [ELAP_W-1:0] elapsed_time;
		logic [3:0]        entry_index;
		logic [DUR_W-1:0]  entry_duration;
	} fds_in_t;

	// Result word.
	typedef struct packed {
		logic [3:0] shown_frame;
		logic       is_running;
		logic       frame_changed;
	} fds_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
	} fds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic tick_go;
		logic fits;
		logic at_end;
		logic lap_done;
		logic loop_en;
	} fds_stat_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_READ   = 4'b0010,
		ST_STEP   = 4'b0100,
		ST_FINISH = 4'b1000
	} fds_state_t;

endpackage

// ===== src/fds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fds_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/fds_datapath.sv =====
// Datapath: configuration, frame position, accumulator, frame table and result register.
module fds_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fds_pkg::fds_in_t                 in_data,
	input  fds_pkg::fds_cmd_t                cmd,
	output fds_pkg::fds_stat_t               stat,
	output fds_pkg::fds_out_t                out_data,
	input  logic                             cfg_we,
	input  logic [fds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fds_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fds_pkg::*;

	logic [CFG_CNT_W-1:0] frame_count_q;
	logic                 loop_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     before_q;
	logic [ACC_WIDTH-1:0] acc_q;
	logic                 running_q;
	logic [CNT_W-1:0]     steps_q;
	fds_out_t             out_q;

	logic [CNT_W-1:0]     count_eff;
	logic [CMP_W-1:0]     pos_ext;
	logic [CMP_W-1:0]     cnt_ext;
	logic [POS_W-1:0]     clamp_pos;
	logic [POS_W-1:0]     pos_inc;
	logic [ACC_WIDTH:0]   sum;
	logic [ACC_WIDTH-1:0] acc_sat;
	logic [ACC_WIDTH-1:0] dur_ext;
	logic [DUR_W-1:0]     rd_data;
	logic [POS_W-1:0]     rd_addr;
	logic                 wr_en;
	logic                 at_end;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			loop_q        <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_FRAME_COUNT) begin
				frame_count_q <= cfg_data[CFG_CNT_W-1:0];
			end
			if (cfg_index == REG_LOOP_ENABLE) begin
				loop_q <= cfg_data[0];
			end
		end
	end

	// Effective frame count saturates at the table depth.
	always_comb begin
		if (CMP_W'(frame_count_q) > CMP_W'(MAX_FRAMES)) begin
			count_eff = CNT_W'(MAX_FRAMES);
		end else begin
			count_eff = CNT_W'(frame_count_q);
		end
	end

	assign pos_ext = CMP_W'(pos_q);
	assign cnt_ext = CMP_W'(count_eff);

	// A tick first pulls a stale position back onto the last frame in use.
	assign clamp_pos = (pos_ext >= cnt_ext) ? POS_W'(count_eff - CNT_W'(1)) : pos_q;

	// Saturating add of the elapsed time.
	assign sum     = {1'b0, acc_q} + (ACC_WIDTH + 1)'(in_data.elapsed_time);
	assign acc_sat = sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum[ACC_WIDTH-1:0];

	// Step decisions for the current frame.
	assign dur_ext = ACC_WIDTH'(rd_data);
	assign at_end  = (pos_ext + CMP_W'(1)) >= cnt_ext;
	assign pos_inc = at_end ? '0 : pos_q + POS_W'(1);

	assign stat.tick_go  = running_q && (count_eff != '0);
	assign stat.fits     = dur_ext <= acc_q;
	assign stat.at_end   = at_end;
	assign stat.lap_done = (steps_q + CNT_W'(1)) == count_eff;
	assign stat.loop_en  = loop_q;

	// While stepping, the table is read one frame ahead.
	assign rd_addr = cmd.step ? pos_inc : pos_q;
	assign wr_en   = cmd.accept && (in_data.operation == OP_WRITE) &&
		(32'(in_data.entry_index) < 32'(MAX_FRAMES));

	fds_ram #(
		.WIDTH(DUR_W),
		.DEPTH(MAX_FRAMES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(POS_W'(in_data.entry_index)),
		.wr_data(in_data.entry_duration),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Sequence state: operations on accept, one frame advance or a stop per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			acc_q     <= '0;
			running_q <= 1'b0;
		end else if (cmd.accept) begin
			unique case (in_data.operation)
				OP_TICK: begin
					if (stat.tick_go) begin
						pos_q <= clamp_pos;
						acc_q <= acc_sat;
					end
				end
				OP_WRITE: begin
				end
				OP_START: begin
					pos_q     <= '0;
					acc_q     <= '0;
					running_q <= 1'b1;
				end
				OP_REWIND: begin
					pos_q <= '0;
					acc_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.step) begin
			acc_q <= acc_q - dur_ext;
			if (at_end && !loop_q) begin
				running_q <= 1'b0;
			end else begin
				pos_q <= pos_inc;
			end
		end
	end

	// Step counter and the position before the word, for the change flag.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			before_q <= pos_q;
			steps_q  <= '0;
		end else if (cmd.step) begin
			steps_q <= steps_q + CNT_W'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.shown_frame   <= 4'(pos_q);
			out_q.is_running    <= running_q;
			out_q.frame_changed <= pos_q != before_q;
		end
	end

	assign out_data = out_q;

endmodule

// ===== src/fds_ctrl.sv =====
// Controller: sequences accept, table walk and result delivery.
module fds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fds_pkg::fds_op_t    op,
	input  fds_pkg::fds_stat_t  stat,
	output fds_pkg::fds_cmd_t   cmd,
	output logic                out_valid,
	input  logic                out_ready
);
	import fds_pkg::*;

	fds_state_t state_q;
	fds_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = state_q == ST_IDLE;

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (op == OP_TICK && stat.tick_go) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_READ: begin
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (!stat.fits) begin
					state_d = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
					if ((stat.at_end && !stat.loop_en) || stat.lap_done) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/frame_duration_sequencer_unit.sv =====
// Top level of the frame duration sequencer.
// The block takes one input word at a time and returns exactly one result word for
// each. A duration write, a start, a rewind, or a tick while the sequence is stopped
// or the frame count is zero, goes from acceptance straight to the finish state. A
// running tick passes through the read state and then the step state, advancing one
// frame per step, at most the frame count, until it completes a full lap, reaches the
// last frame without looping, or stops at a frame whose duration does not yet fit.
// The longest ticks are a full lap of 16 frames, or 15 advances followed by a frame
// that does not fit. The finish state loads the result register once the output is
// free. The frame table is read once per cycle with one frame of lookahead. A new
// word is accepted while an earlier result still waits in the output register. Its
// own result is then held back until the earlier one is taken. Configuration writes
// are always accepted and must be issued only while the block is idle. The frame
// table is not cleared at reset.
module frame_duration_sequencer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  fds_pkg::fds_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output fds_pkg::fds_out_t              out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fds_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fds_pkg::*;

	fds_cmd_t  cmd;
	fds_stat_t stat;

	assign cfg_ready = 1'b1;

	// Controller.
	fds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (in_data.operation),
		.stat     (stat),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	// Datapath.
	fds_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule

// ===== src/fds_checker.sv =====
// Port-level checks for the frame duration sequencer, bound to the top level.
module fds_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input fds_pkg::fds_in_t               in_data,
	input logic                           out_valid,
	input logic                           out_ready,
	input fds_pkg::fds_out_t              out_data,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [fds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [fds_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fds_pkg::*;

	// A stalled result word holds steady.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// A waiting input word holds steady.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while waiting");

	// The block works on one word at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is in progress");

	// A new result appears only when a word has been in progress.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in progress");

	// Register writes arrive only while the block is idle, with known contents.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> in_ready && !out_valid &&
			!$isunknown({cfg_index, cfg_data}))
		else $error("register written while a word is in flight");

endmodule

bind frame_duration_sequencer_unit fds_checker u_fds_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for the frame duration sequencer top level.
`timescale 1ns / 1ps

module testbench;
	import fds_pkg::*;

	// Tracks the frame position, accumulator and duration table, and compares each
	// result word with the oldest predicted one.
	class frame_tracker;
		logic [DUR_W-1:0]     durations [MAX_FRAMES];
		int unsigned          position;
		logic [ACC_WIDTH-1:0] accum;
		logic                 running;
		logic [4:0]           frame_count;
		logic                 loop_on;
		fds_out_t             expected_results [$];
		int unsigned          errors;
		int unsigned          results_checked;
		int unsigned          frames_moved;
		int unsigned          runs_ended;

		function new();
			position        = 0;
			accum           = '0;
			running         = 1'b0;
			frame_count     = '0;
			loop_on         = 1'b0;
			errors          = 0;
			results_checked = 0;
			frames_moved    = 0;
			runs_ended      = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_FRAME_COUNT) begin
				frame_count = data[4:0];
			end else begin
				loop_on = data[0];
			end
		endfunction

		// Adds elapsed time and walks the table, at most one lap per tick.
		function void advance(logic [ELAP_W-1:0] elapsed);
			int unsigned          count;
			int unsigned          steps;
			logic [ACC_WIDTH:0]   sum;
			logic [ACC_WIDTH-1:0] dur;
			count = (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
			if (!running || count == 0)
				return;
			if (position >= count)
				position = count - 1;
			sum   = {1'b0, accum} + elapsed;
			accum = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
			for (steps = 0; steps < count; steps++) begin
				dur = durations[position];
				if (dur > accum)
					break;
				accum = accum - dur;
				if (position == count - 1) begin
					if (loop_on) begin
						position = 0;
					end else begin
						running = 1'b0;
						runs_ended++;
						break;
					end
				end else begin
					position++;
				end
			end
		endfunction

		// Applies one accepted input word and queues the result it must produce.
		function void note_word(fds_in_t w);
			int unsigned prior;
			fds_out_t    r;
			prior = position;
			case (w.operation)
				OP_TICK: begin
					advance(w.elapsed_time);
				end
				OP_WRITE: begin
					durations[w.entry_index] = w.entry_duration;
				end
				OP_START: begin
					position = 0;
					accum    = '0;
					running  = 1'b1;
				end
				default: begin
					position = 0;
					accum    = '0;
				end
			endcase
			r.shown_frame   = position[3:0];
			r.is_running    = running;
			r.frame_changed = (position != prior);
			if (r.frame_changed)
				frames_moved++;
			expected_results.insert(expected_results.size(), r);
		endfunction

		function void report_mismatch(string what, int unsigned got, int unsigned want);
			$display("MISMATCH result %0d: %s got %0d, expected %0d",
				results_checked, what, got, want);
			errors++;
		endfunction

		function void check_result(fds_out_t r);
			fds_out_t want;
			if (expected_results.size() == 0) begin
				$display("MISMATCH: result word with no input word outstanding");
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (r.shown_frame !== want.shown_frame)
				report_mismatch("shown_frame", r.shown_frame, want.shown_frame);
			if (r.is_running !== want.is_running)
				report_mismatch("is_running", r.is_running, want.is_running);
			if (r.frame_changed !== want.frame_changed)
				report_mismatch("frame_changed", r.frame_changed, want.frame_changed);
			results_checked++;
		endfunction
	endclass

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_WAIT  = 25;
	localparam int PHASES       = 9;
	localparam int PHASE_WORDS  = 104;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	fds_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	fds_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	frame_tracker tracker = new();
	int unsigned  send_idle_pct = 11;
	int unsigned  recv_idle_pct = 84;
	int unsigned  words_sent    = 0;
	int unsigned  cycles        = 0;

	frame_duration_sequencer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: check every accepted word, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(out_data);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("** frame_duration_sequencer_unit: FAILED **");
			$finish;
		end
	end

	// Presents one input word, with random idle cycles ahead of it.
	task automatic send_word(fds_in_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		tracker.note_word(w);
		words_sent++;
	endtask

	// Writes one register, then leaves the channel idle.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Lets every outstanding result come back, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_duration();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 40) return 16'($urandom_range(63));
		if (roll < 65) return 16'($urandom_range(600));
		if (roll < 75) return 16'd0;
		if (roll < 85) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_elapsed();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 35) return 16'($urandom_range(100));
		if (roll < 65) return 16'($urandom_range(800));
		if (roll < 75) return 16'd0;
		if (roll < 85) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// Mostly ticks, with enough starts to keep stopped sequences going.
	function automatic fds_in_t random_word();
		fds_in_t     w;
		int unsigned roll;
		roll             = $urandom_range(99);
		w.operation      = (roll < 65) ? OP_TICK : (roll < 80) ? OP_WRITE :
			(roll < 92) ? OP_START : OP_REWIND;
		w.elapsed_time   = pick_elapsed();
		w.entry_index    = 4'($urandom_range(15));
		w.entry_duration = pick_duration();
		return w;
	endfunction

	function automatic fds_in_t make_word(fds_op_t op, logic [15:0] elapsed,
		logic [3:0] idx, logic [15:0] dur);
		fds_in_t w;
		w.operation      = op;
		w.elapsed_time   = elapsed;
		w.entry_index    = idx;
		w.entry_duration = dur;
		return w;
	endfunction

	initial begin
		int          phase_count [PHASES] = '{16, 5, 0, 31, 1, 16, 9, 17, 3};
		bit          phase_loop  [PHASES] = '{1, 0, 1, 1, 0, 0, 1, 0, 1};
		logic [15:0] dur;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: four frames, no looping.
		write_register(REG_FRAME_COUNT, 5'd4);
		write_register(REG_LOOP_ENABLE, 5'd0);
		send_word(make_word(OP_TICK, 16'hFFFF, 4'hF, 16'hFFFF));
		for (int i = 0; i < MAX_FRAMES; i++) begin
			dur = (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : (i == 2) ? 16'd1 : 16'(i * 37);
			send_word(make_word(OP_WRITE, 16'd0, 4'(i), dur));
		end
		send_word(make_word(OP_START, 16'd0, 4'd0, 16'd0));
		// A zero-length frame is skipped by a tick with no elapsed time.
		send_word(make_word(OP_TICK, 16'd0, 4'd0, 16'd0));
		send_word(make_word(OP_TICK, 16'hFFFF, 4'd0, 16'd0));
		// This tick runs off the end and stops the sequence.
		send_word(make_word(OP_TICK, 16'hFFFF, 4'd0, 16'd0));
		send_word(make_word(OP_REWIND, 16'hFFFF, 4'hF, 16'hFFFF));
		send_word(make_word(OP_START, 16'hFFFF, 4'hF, 16'hFFFF));
		send_word(make_word(OP_REWIND, 16'd0, 4'd0, 16'd0));
		send_word(make_word(OP_TICK, 16'd1000, 4'd0, 16'd0));
		drain();

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			if (p == 3) begin
				send_idle_pct = 84;
				recv_idle_pct = 11;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_register(REG_FRAME_COUNT, 5'(phase_count[p]));
			write_register(REG_LOOP_ENABLE, {4'($urandom_range(15)), phase_loop[p]});
			for (int n = 0; n < PHASE_WORDS; n++)
				send_word(random_word());
			drain();
		end

		$display("Sent %0d input words over %0d register settings; %0d results checked.",
			words_sent, PHASES + 1, tracker.results_checked);
		$display("Shown frame moved %0d times; %0d sequences ran to their end.",
			tracker.frames_moved, tracker.runs_ended);
		if (tracker.errors == 0) begin
			$display("** frame_duration_sequencer_unit: PASSED **");
		end else begin
			$display("** frame_duration_sequencer_unit: FAILED **");
		end
		$finish;
	end

endmodule
